[design/ir_remote_pulse_decoder_core_macros.svh]
// Assertion helpers for the decoder. Both macros sample on clk_i and are
// disabled while rst_ni is low, so they expect those names in scope.
`ifndef IR_REMOTE_PULSE_DECODER_CORE_MACROS_SVH
`define IR_REMOTE_PULSE_DECODER_CORE_MACROS_SVH

// Holds a temporal property on every clock edge outside reset.
`define IRPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("irpd assertion failed");

// Flags a condition that must never be true outside reset.
`define IRPD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("irpd forbidden condition seen");

`endif

[design/irpd_pkg.sv]
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 4;
  localparam int unsigned CODE_W          = 32;
  localparam int unsigned TICK_W          = 8;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [CODE_W-1:0] EXPECTED_RST = {8'hE0, 8'hE0, 8'h36, 8'hC9};
  localparam logic [TICK_W-1:0] LEADER_MIN_RST = 8'd90;
  localparam logic [TICK_W-1:0] LEADER_MAX_RST = 8'd110;
  localparam logic [TICK_W-1:0] SHORT_MIN_RST  = 8'd9;
  localparam logic [TICK_W-1:0] SHORT_MAX_RST  = 8'd18;
  localparam logic [TICK_W-1:0] LONG_MIN_RST   = 8'd33;
  localparam logic [TICK_W-1:0] LONG_MAX_RST   = 8'd45;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED   = 3'd0,
    CFG_LEADER_MIN = 3'd1,
    CFG_LEADER_MAX = 3'd2,
    CFG_SHORT_MIN  = 3'd3,
    CFG_SHORT_MAX  = 3'd4,
    CFG_LONG_MIN   = 3'd5,
    CFG_LONG_MAX   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAGE_LEAD_LOW  = 2'd0,
    STAGE_LEAD_HIGH = 2'd1,
    STAGE_GAP       = 2'd2,
    STAGE_BIT       = 2'd3
  } stage_e;

  typedef struct packed {
    logic [CODE_W-1:0] expected;
    logic [TICK_W-1:0] leader_min;
    logic [TICK_W-1:0] leader_max;
    logic [TICK_W-1:0] short_min;
    logic [TICK_W-1:0] short_max;
    logic [TICK_W-1:0] long_min;
    logic [TICK_W-1:0] long_max;
  } cfg_t;

  // Level change seen on the sample being accepted.
  typedef struct packed {
    logic              strobe;
    logic              was_high;
    logic [TICK_W-1:0] ticks;
  } pulse_t;

  // Frame tracker status seen by the top level.
  typedef struct packed {
    stage_e stage;
    logic   last_bit;
    logic   done;
  } frame_stat_t;

endpackage

[design/irpd_if.sv]
`timescale 1ns / 1ps

interface irpd_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface irpd_out_if;
  logic                             valid;
  logic                             ready;
  logic [irpd_pkg::CODE_W-1:0]      code;
  logic                             match;

  modport source (output valid, output code, output match, input ready);
  modport sink   (input valid, input code, input match, output ready);
endinterface

[design/irpd_cfg_regs.sv]
`timescale 1ns / 1ps

module irpd_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [irpd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output irpd_pkg::cfg_t                    cfg_o
);

  irpd_pkg::cfg_t cfg_q;
  logic [irpd_pkg::TICK_W-1:0] byte_val;

  assign byte_val = cfg_wdata_i[irpd_pkg::TICK_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected   <= irpd_pkg::EXPECTED_RST;
      cfg_q.leader_min <= irpd_pkg::LEADER_MIN_RST;
      cfg_q.leader_max <= irpd_pkg::LEADER_MAX_RST;
      cfg_q.short_min  <= irpd_pkg::SHORT_MIN_RST;
      cfg_q.short_max  <= irpd_pkg::SHORT_MAX_RST;
      cfg_q.long_min   <= irpd_pkg::LONG_MIN_RST;
      cfg_q.long_max   <= irpd_pkg::LONG_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        irpd_pkg::CFG_EXPECTED:   cfg_q.expected   <= cfg_wdata_i[irpd_pkg::CODE_W-1:0];
        irpd_pkg::CFG_LEADER_MIN: cfg_q.leader_min <= byte_val;
        irpd_pkg::CFG_LEADER_MAX: cfg_q.leader_max <= byte_val;
        irpd_pkg::CFG_SHORT_MIN:  cfg_q.short_min  <= byte_val;
        irpd_pkg::CFG_SHORT_MAX:  cfg_q.short_max  <= byte_val;
        irpd_pkg::CFG_LONG_MIN:   cfg_q.long_min   <= byte_val;
        irpd_pkg::CFG_LONG_MAX:   cfg_q.long_max   <= byte_val;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/irpd_pulse_timer.sv]
`timescale 1ns / 1ps

module irpd_pulse_timer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             level_i,
  output irpd_pkg::pulse_t pulse_o
);

  logic                        level_q, level_d;
  logic [irpd_pkg::TICK_W-1:0] ticks_q, ticks_d;
  logic                        change;

  assign change = level_i != level_q;

  always_comb begin
    level_d = level_q;
    ticks_d = ticks_q;
    if (accept_i) begin
      if (change) begin
        level_d = level_i;
        ticks_d = '0;
      end else if (ticks_q != irpd_pkg::TICK_MAX) begin
        ticks_d = ticks_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
      ticks_q <= '0;
    end else begin
      level_q <= level_d;
      ticks_q <= ticks_d;
    end
  end

  // The level that just ended is the stored one; its length is the count.
  assign pulse_o.strobe   = accept_i & change;
  assign pulse_o.was_high = level_q;
  assign pulse_o.ticks    = ticks_q;

endmodule

[design/irpd_frame_fsm.sv]
`timescale 1ns / 1ps

module irpd_frame_fsm #(
  parameter int unsigned FRAME_BYTES = irpd_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  irpd_pkg::cfg_t               cfg_i,
  input  irpd_pkg::pulse_t             pulse_i,
  output irpd_pkg::frame_stat_t        stat_o,
  output logic [irpd_pkg::CODE_W-1:0]  code_o,
  output logic                         match_o
);

  localparam int unsigned FRAME_BITS = FRAME_BYTES * 8;
  localparam int unsigned IDX_W      = $clog2(FRAME_BITS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BITS - 1);

  irpd_pkg::stage_e            stage_q, stage_d;
  logic [irpd_pkg::CODE_W-1:0] shift_q, shift_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        done;
  logic                        lead, shrt, lng;
  logic [irpd_pkg::TICK_W-1:0] n;

  assign n    = pulse_i.ticks;
  assign lead = (n > cfg_i.leader_min) && (n < cfg_i.leader_max);
  assign shrt = (n > cfg_i.short_min) && (n < cfg_i.short_max);
  assign lng  = (n > cfg_i.long_min) && (n < cfg_i.long_max);

  always_comb begin
    logic bad;
    bad     = 1'b0;
    stage_d = stage_q;
    shift_d = shift_q;
    idx_d   = idx_q;
    done    = 1'b0;
    if (pulse_i.strobe) begin
      unique case (stage_q)
        irpd_pkg::STAGE_LEAD_LOW: begin
          if (!pulse_i.was_high && lead) stage_d = irpd_pkg::STAGE_LEAD_HIGH;
          else bad = 1'b1;
        end
        irpd_pkg::STAGE_LEAD_HIGH: begin
          if (pulse_i.was_high && lead) stage_d = irpd_pkg::STAGE_GAP;
          else bad = 1'b1;
        end
        irpd_pkg::STAGE_GAP: begin
          if (!pulse_i.was_high && shrt) stage_d = irpd_pkg::STAGE_BIT;
          else bad = 1'b1;
        end
        irpd_pkg::STAGE_BIT: begin
          if (pulse_i.was_high && (shrt || lng)) begin
            // A pulse inside both windows counts as a one.
            shift_d = {shift_q[irpd_pkg::CODE_W-2:0], lng};
            stage_d = irpd_pkg::STAGE_GAP;
            if (idx_q == LAST_IDX) begin
              done    = 1'b1;
              stage_d = irpd_pkg::STAGE_LEAD_LOW;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        stage_d = irpd_pkg::STAGE_LEAD_LOW;
        idx_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= irpd_pkg::STAGE_LEAD_LOW;
      shift_q <= '0;
      idx_q   <= '0;
    end else begin
      stage_q <= stage_d;
      shift_q <= shift_d;
      idx_q   <= idx_d;
    end
  end

  assign stat_o.stage    = stage_q;
  assign stat_o.last_bit = idx_q == LAST_IDX;
  assign stat_o.done     = done;
  assign code_o          = shift_d;
  assign match_o         = shift_d == cfg_i.expected;

endmodule

[design/irpd_result_reg.sv]
`timescale 1ns / 1ps

module irpd_result_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [irpd_pkg::CODE_W-1:0] code_i,
  input  logic                        match_i,
  irpd_out_if.source                  out_if
);

  logic                        valid_q, valid_d;
  logic [irpd_pkg::CODE_W-1:0] code_q;
  logic                        match_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) valid_d = 1'b1;
    else if (out_if.ready) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      code_q  <= code_i;
      match_q <= match_i;
    end
  end

  assign out_if.valid = valid_q;
  assign out_if.code  = code_q;
  assign out_if.match = match_q;

endmodule

[design/ir_remote_pulse_decoder_core.sv]
// Infrared remote frame decoder, pulse-distance coded, one sampled receiver
// level per request on the input channel (valid/ready, field level).
// Each request extends the length of the current level, saturating at 255.
// When the level changes, the length of the level that just ended is
// checked against the window of the current stage: leader low, leader high,
// bit gap, then bit pulse, where a short pulse is a 0 and a long one a 1.
// After the last bit of the frame the output channel carries one request
// with the received code and a match flag against the expected code.
// Throughput is one sample per cycle when not held back; the decision is
// a few 8-bit window compares, a 32-bit shift and one 32-bit equality
// compare. Latency: the result is valid the cycle after the completing
// sample. The output sits in a single result register. When the receiver
// stalls, samples keep being taken, except for a sample that could complete
// a frame while the result register is still full and not being drained.
// Reset clears the stage, bit count and tick count, sets the remembered
// level high and loads the configuration registers with their defaults.
// Configuration writes land on the next clock edge and should only be made
// while the block is idle.
`timescale 1ns / 1ps
`include "ir_remote_pulse_decoder_core_macros.svh"

module ir_remote_pulse_decoder_core #(
  parameter int unsigned FRAME_BYTES = irpd_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  irpd_in_if.sink                         in_if,
  irpd_out_if.source                      out_if
);

  irpd_pkg::cfg_t              cfg;
  irpd_pkg::pulse_t            pulse;
  irpd_pkg::frame_stat_t       stat;
  logic [irpd_pkg::CODE_W-1:0] frame_code;
  logic                        frame_match;
  logic                        accept;
  logic                        may_finish;

  // Only a bit pulse at the last bit position can finish a frame, so the
  // input waits on the output side only in that state.
  assign may_finish  = (stat.stage == irpd_pkg::STAGE_BIT) && stat.last_bit;
  assign in_if.ready = !may_finish || !out_if.valid || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  irpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irpd_pulse_timer u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .level_i  (in_if.level),
    .pulse_o  (pulse)
  );

  irpd_frame_fsm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pulse_i (pulse),
    .stat_o  (stat),
    .code_o  (frame_code),
    .match_o (frame_match)
  );

  irpd_result_reg u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stat.done),
    .code_i  (frame_code),
    .match_i (frame_match),
    .out_if  (out_if)
  );

  // A finished frame never overwrites a result that is still waiting.
  `IRPD_ASSERT_NEVER(a_no_overwrite, stat.done && out_if.valid && !out_if.ready)
  // A finished frame shows up on the output in the next cycle.
  `IRPD_ASSERT(a_done_to_out, stat.done |=> out_if.valid)
  // A new result only follows a sample taken in the bit stage.
  `IRPD_ASSERT(a_out_from_bit, $rose(out_if.valid) |-> $past(may_finish))

endmodule

[test/tb_ir_remote_pulse_decoder_core.sv]
`timescale 1ns / 1ps

module tb_ir_remote_pulse_decoder_core;
  import irpd_pkg::*;

  localparam int FRAME_BITS    = FRAME_BYTES_DEF * 8;
  // The slowest correct run is roughly 40k samples.
  // The limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // The result shows up the cycle after the completing sample.
  // The extra settle cycles cover a sample still in flight.
  localparam int SETTLE_CYCLES = 4;

  // How pulse lengths are picked inside a window.
  typedef enum {LEN_MID, LEN_LOWEST, LEN_HIGHEST, LEN_ANY} len_mode_e;
  typedef enum {ROW_RUN, ROW_FRAME} row_kind_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              match;
  } frame_t;

  // A directed row is either a run of one level held for len samples, or a
  // frame of len bits. Only rows with typed set carry a hand-written result.
  typedef struct {
    row_kind_e         kind;
    logic              lvl;
    int                len;
    logic [CODE_W-1:0] word;
    len_mode_e         mode;
    bit                typed;
    logic              match;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  irpd_in_if  in_ch ();
  irpd_out_if out_ch ();

  ir_remote_pulse_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // Decoder state as this bench tracks it, plus the live window settings.
  cfg_t              win_now;
  logic              line_level;
  logic [TICK_W-1:0] run_ticks;
  stage_e            frame_stage;
  logic [CODE_W-1:0] frame_word;
  int                bits_taken;

  frame_t frames_due[$];
  frame_t oldest;
  bit     typed_row;
  int     samples_in;
  int     frames_out;
  int     mismatches;
  int     cycles;
  int     src_gap_pct;
  int     snk_stall_pct;

  // Directed pass, all at the reset windows: leader 90..110, short 9..18,
  // long 33..45, expected code E0E036C9.
  row_t plan [13] = '{
    // A high level that fits the leader window but ends in the leader low
    // stage: wrong level for the stage.
    '{ROW_RUN,   1'b1, 100, 32'h0000_0000, LEN_MID,     1'b0, 1'b0},
    // Low held long enough for the tick counter to saturate.
    '{ROW_RUN,   1'b0, 300, 32'h0000_0000, LEN_MID,     1'b0, 1'b0},
    // Single-sample pulses: the count restarts at zero on every edge.
    '{ROW_RUN,   1'b1, 1,   32'h0000_0000, LEN_MID,     1'b0, 1'b0},
    '{ROW_RUN,   1'b0, 1,   32'h0000_0000, LEN_MID,     1'b0, 1'b0},
    // Full frames: the reset expected code matches, the extremes do not.
    '{ROW_FRAME, 1'b0, 32,  32'hE0E0_36C9, LEN_MID,     1'b1, 1'b1},
    '{ROW_FRAME, 1'b0, 32,  32'h0000_0000, LEN_LOWEST,  1'b1, 1'b0},
    '{ROW_FRAME, 1'b0, 32,  32'hFFFF_FFFF, LEN_HIGHEST, 1'b1, 1'b0},
    // A frame cut off after 12 bits, then a bad edge.
    '{ROW_FRAME, 1'b0, 12,  32'hA5A5_A5A5, LEN_MID,     1'b0, 1'b0},
    '{ROW_RUN,   1'b1, 60,  32'h0000_0000, LEN_MID,     1'b0, 1'b0},
    // The leftover bits must be shifted out completely by the next frame.
    '{ROW_FRAME, 1'b0, 32,  32'h1234_5678, LEN_MID,     1'b1, 1'b0},
    // Pulses sitting exactly on the exclusive leader bounds.
    '{ROW_RUN,   1'b0, 90,  32'h0000_0000, LEN_MID,     1'b0, 1'b0},
    '{ROW_RUN,   1'b1, 111, 32'h0000_0000, LEN_MID,     1'b0, 1'b0},
    '{ROW_RUN,   1'b0, 2,   32'h0000_0000, LEN_MID,     1'b0, 1'b0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL ir_remote_pulse_decoder_core");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  // Every frame the decoder hands over is checked against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      frames_out++;
      if (frames_due.size() == 0) begin
        $error("code: expected none, actual %h", out_ch.code);
        mismatches++;
      end else begin
        oldest = frames_due.pop_front();
        if (out_ch.code !== oldest.code) begin
          $error("code: expected %h, actual %h", oldest.code, out_ch.code);
          mismatches++;
        end
        if (out_ch.match !== oldest.match) begin
          $error("match: expected %b, actual %b", oldest.match, out_ch.match);
          mismatches++;
        end
      end
    end
  end

  // Steps the tracked decoder by one accepted sample and queues the frame
  // it completes, if any.
  task automatic decode_level(input logic lvl);
    logic [TICK_W-1:0] n;
    logic              was_high;
    logic              lead;
    logic              shrt;
    logic              lng;
    n        = run_ticks;
    was_high = line_level;
    lead     = n > win_now.leader_min && n < win_now.leader_max;
    shrt     = n > win_now.short_min && n < win_now.short_max;
    lng      = n > win_now.long_min && n < win_now.long_max;
    if (lvl == line_level) begin
      if (run_ticks != TICK_MAX) run_ticks++;
    end else begin
      if ((frame_stage == STAGE_LEAD_LOW && !was_high && lead) ||
          (frame_stage == STAGE_LEAD_HIGH && was_high && lead) ||
          (frame_stage == STAGE_GAP && !was_high && shrt)) begin
        frame_stage = stage_e'(frame_stage + 2'd1);
      end else if (frame_stage == STAGE_BIT && was_high && (shrt || lng)) begin
        // When both bit windows hold the pulse, the long one wins.
        frame_stage = STAGE_GAP;
        frame_word  = {frame_word[CODE_W-2:0], lng};
        bits_taken++;
        if (bits_taken >= FRAME_BITS) begin
          if (!typed_row) frames_due.push_back('{frame_word, frame_word == win_now.expected});
          frame_stage = STAGE_LEAD_LOW;
          bits_taken  = 0;
        end
      end else begin
        // Bad edge: the word keeps its bits, only the position restarts.
        frame_stage = STAGE_LEAD_LOW;
        bits_taken  = 0;
      end
      line_level = lvl;
      run_ticks  = '0;
    end
  endtask

  task automatic drive_sample(input logic lvl);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.level <= lvl;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    samples_in++;
    decode_level(lvl);
  endtask

  task automatic send_run(input logic lvl, input int count);
    repeat (count) drive_sample(lvl);
  endtask

  // Tick count for a pulse inside the exclusive window lo..hi. An empty
  // window gives a short arbitrary length. Outside the mid mode, wide windows
  // are sampled near their low end so that frames stay short.
  function automatic int pulse_len(input logic [7:0] lo, input logic [7:0] hi,
                                   input len_mode_e mode);
    int span;
    span = int'(hi) - int'(lo) - 1;
    if (span < 1) return $urandom_range(20);
    if (mode == LEN_MID) return (int'(lo) + int'(hi)) / 2;
    if (mode == LEN_LOWEST && span <= 40) return int'(lo) + 1;
    if (mode == LEN_HIGHEST && span <= 40) return int'(hi) - 1;
    return int'(lo) + 1 + $urandom_range(span > 12 ? 11 : span - 1);
  endfunction

  // A zero bit needs a short pulse that stays out of the long window.
  function automatic int zero_len(input len_mode_e mode);
    int n;
    n = pulse_len(win_now.short_min, win_now.short_max, mode);
    for (int t = 0; t < 8 && n > int'(win_now.long_min) && n < int'(win_now.long_max); t++)
      n = pulse_len(win_now.short_min, win_now.short_max, mode);
    return n;
  endfunction

  // Sends a frame of nbits bits, most significant first, and ends it with a
  // single low sample so that the last bit pulse sees its falling edge.
  task automatic send_frame(input logic [CODE_W-1:0] word, input int nbits,
                            input len_mode_e mode);
    int n;
    // A one-sample high, a one-sample low and then some idle high always
    // leave the decoder in leader low, whatever came before.
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1 + $urandom_range(12));
    send_run(1'b0, pulse_len(win_now.leader_min, win_now.leader_max, mode) + 1);
    send_run(1'b1, pulse_len(win_now.leader_min, win_now.leader_max, mode) + 1);
    for (int i = 0; i < nbits; i++) begin
      send_run(1'b0, pulse_len(win_now.short_min, win_now.short_max, mode) + 1);
      if (word[CODE_W-1-i]) n = pulse_len(win_now.long_min, win_now.long_max, mode);
      else n = zero_len(mode);
      send_run(1'b1, n + 1);
    end
    send_run(1'b0, 1);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Holds the sender back until every frame due has come out.
  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int          goal_samples;
    int          goal_frames;
    int          round;
    int          seqs;
    int          pick;
    cfg_t        win;
    logic [31:0] word;
    len_mode_e   mode;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_EXPECTED;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.level   = 1'b1;
    out_ch.ready  = 1'b0;
    typed_row     = 1'b0;
    samples_in    = 0;
    frames_out    = 0;
    mismatches    = 0;
    cycles        = 0;
    src_gap_pct   = 9;
    snk_stall_pct = 66;
    win_now       = '{EXPECTED_RST, LEADER_MIN_RST, LEADER_MAX_RST, SHORT_MIN_RST,
                      SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST};
    line_level    = 1'b1;
    run_ticks     = '0;
    frame_stage   = STAGE_LEAD_LOW;
    frame_word    = '0;
    bits_taken    = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_RUN) begin
        send_run(plan[i].lvl, plan[i].len);
      end else begin
        if (plan[i].typed) frames_due.push_back('{plan[i].word, plan[i].match});
        typed_row = plan[i].typed;
        send_frame(plan[i].word, plan[i].len, plan[i].mode);
        typed_row = 1'b0;
      end
    end

    // Random part in three stretches: slow receiver, slow sender, no gaps.
    // Each round loads a new set of windows while the decoder is idle.
    round = 0;
    for (int p = 0; p < 3; p++) begin
      src_gap_pct   = (p == 0) ? 9 : (p == 1) ? 66 : 0;
      snk_stall_pct = (p == 0) ? 66 : (p == 1) ? 9 : 0;
      goal_samples  = samples_in + 500;
      goal_frames   = frames_out + 15;
      while (samples_in < goal_samples || frames_out < goal_frames) begin
        drain_frames();
        case (round % 10)
          0: win = '{$urandom, 8'd3, 8'd8, 8'd0, 8'd4, 8'd4, 8'd10};
          // Leader only fits at 254 ticks, right below the saturated count.
          1: win = '{$urandom, 8'd253, 8'd255, 8'd1, 8'd4, 8'd4, 8'd9};
          // Short and long windows overlap on 5 to 9 ticks.
          3: win = '{$urandom, 8'd2, 8'd7, 8'd1, 8'd10, 8'd4, 8'd12};
          4: win = '{EXPECTED_RST, LEADER_MIN_RST, LEADER_MAX_RST, SHORT_MIN_RST,
                     SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST};
          // Fully open windows: every bit decodes as a one.
          6: win = '{32'hFFFF_FFFF, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
          // Empty and inverted windows: nothing can ever decode.
          7: win = '{$urandom, 8'd200, 8'd10, 8'd0, 8'd1, 8'd255, 8'd255};
          default: begin
            win.expected   = $urandom;
            win.leader_min = 8'($urandom_range(20));
            win.leader_max = win.leader_min + 8'(2 + $urandom_range(6));
            win.short_min  = 8'($urandom_range(5));
            win.short_max  = win.short_min + 8'(2 + $urandom_range(4));
            win.long_min   = 8'($urandom_range(12));
            win.long_max   = win.long_min + 8'(2 + $urandom_range(6));
            if ($urandom_range(5) == 0) win.long_max = 8'($urandom);
          end
        endcase
        win_now = win;
        write_reg(CFG_EXPECTED,   win.expected);
        write_reg(CFG_LEADER_MIN, CFG_DATA_W'(win.leader_min));
        write_reg(CFG_LEADER_MAX, CFG_DATA_W'(win.leader_max));
        write_reg(CFG_SHORT_MIN,  CFG_DATA_W'(win.short_min));
        write_reg(CFG_SHORT_MAX,  CFG_DATA_W'(win.short_max));
        write_reg(CFG_LONG_MIN,   CFG_DATA_W'(win.long_min));
        write_reg(CFG_LONG_MAX,   CFG_DATA_W'(win.long_max));
        cfg_we_i <= 1'b0;

        // Slow settings get only a couple of sequences per round.
        seqs = (round % 10 == 1 || round % 10 == 4) ? 2 : 8;
        repeat (seqs) begin
          case ($urandom_range(2))
            0:       word = win_now.expected;
            1:       word = win_now.expected ^ (32'h1 << $urandom_range(31));
            default: word = $urandom;
          endcase
          pick = $urandom_range(9);
          mode = (pick == 0) ? LEN_LOWEST : (pick == 1) ? LEN_HIGHEST : LEN_ANY;
          pick = $urandom_range(99);
          if (pick < 70) begin
            send_frame(word, FRAME_BITS, mode);
          end else if (pick < 85) begin
            // Cut the frame short and follow it with a pulse of any length.
            send_frame(word, $urandom_range(FRAME_BITS - 1), mode);
            send_run(1'($urandom_range(1)), 1 + $urandom_range(30));
          end else begin
            repeat (1 + $urandom_range(5))
              send_run(1'($urandom_range(1)),
                       ($urandom_range(49) == 0) ? 256 + $urandom_range(44)
                                                 : 1 + $urandom_range(20));
          end
        end
        round++;
      end
    end

    drain_frames();
    if (mismatches == 0) begin
      $display("PASS ir_remote_pulse_decoder_core");
    end else begin
      $display("FAIL ir_remote_pulse_decoder_core");
    end
    $finish;
  end

endmodule

[ir_remote_pulse_decoder_core.f]
+incdir+design
design/irpd_pkg.sv
design/irpd_if.sv
design/irpd_cfg_regs.sv
design/irpd_pulse_timer.sv
design/irpd_frame_fsm.sv
design/irpd_result_reg.sv
design/ir_remote_pulse_decoder_core.sv
test/tb_ir_remote_pulse_decoder_core.sv
